@@ src/hkrb_pkg.sv @@
// Package for the HID key report builder.
// Holds request codes, key usage constants and the controller command type.
// No dependencies.
package hkrb_pkg;

  // Report geometry.
  localparam int NUM_SLOTS = 6;

  // Request type codes.
  localparam logic [1:0] REQ_PRESS       = 2'd0;
  localparam logic [1:0] REQ_RELEASE     = 2'd1;
  localparam logic [1:0] REQ_RELEASE_ALL = 2'd2;
  localparam logic [1:0] REQ_RELEASE_SFT = 2'd3;

  // Key code constants.
  localparam logic [15:0] SHIFT_FLAG_MASK = 16'd4096;
  localparam logic [15:0] MOD_FIRST       = 16'd224;
  localparam logic [15:0] MOD_LAST        = 16'd231;
  localparam logic [15:0] MEDIA_FIRST     = 16'd8193;
  localparam logic [15:0] MEDIA_LAST      = 16'd8200;
  localparam logic [7:0]  LSHIFT_BIT      = 8'h02;
  localparam logic [7:0]  BOTH_SHIFT_BITS = 8'h22;
  localparam logic [7:0]  LSHIFT_CODE     = 8'd225;
  localparam logic [7:0]  RSHIFT_CODE     = 8'd229;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load;
  } ctrl_cmd_t;

endpackage

@@ src/hkrb_ctrl.sv @@
// Controller for the HID key report builder.
// Runs the request and result handshakes. Depends on hkrb_pkg.
module hkrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hkrb_pkg::ctrl_cmd_t cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state;
  logic state_next;

  // A new request is taken when the result register is empty or being drained.
  assign in_ready  = (state == ST_EMPTY) || out_ready;
  assign out_valid = (state == ST_FULL);
  assign cmd.load  = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: begin
        if (cmd.load) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !cmd.load) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/hkrb_datapath.sv @@
// Datapath for the HID key report builder.
// Holds the modifier byte, key slots and media bitmap. Depends on hkrb_pkg.
module hkrb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hkrb_pkg::ctrl_cmd_t cmd,
  input  logic [1:0]          req_type,
  input  logic [15:0]         key_code,
  output logic [7:0]          modifier_bits,
  output logic [7:0]          slots [hkrb_pkg::NUM_SLOTS],
  output logic [7:0]          media_bits,
  output logic                status
);

  logic [7:0]  modifier_next;
  logic [7:0]  slots_next [hkrb_pkg::NUM_SLOTS];
  logic [7:0]  media_next;
  logic        status_next;

  logic        is_media;
  logic [7:0]  media_mask;
  logic        has_shift;
  logic [15:0] kk_shift;
  logic        is_mod;
  logic [7:0]  mod_mask;
  logic [15:0] kk;
  logic [7:0]  set_mask;
  logic        present;
  logic        any_free;
  logic [hkrb_pkg::NUM_SLOTS-1:0] first_free;

  // Decode the key code: media key, shift flag and modifier usage.
  always_comb begin
    is_media   = (key_code >= hkrb_pkg::MEDIA_FIRST) && (key_code <= hkrb_pkg::MEDIA_LAST);
    media_mask = 8'd1 << 3'(key_code - hkrb_pkg::MEDIA_FIRST);
    has_shift  = (key_code & hkrb_pkg::SHIFT_FLAG_MASK) != 16'd0;
    kk_shift   = has_shift ? {8'd0, key_code[7:0]} : key_code;
    is_mod     = (kk_shift >= hkrb_pkg::MOD_FIRST) && (kk_shift <= hkrb_pkg::MOD_LAST);
    mod_mask   = 8'd1 << kk_shift[2:0];
    kk         = is_mod ? 16'd0 : kk_shift;
    set_mask   = (has_shift ? hkrb_pkg::LSHIFT_BIT : 8'd0) | (is_mod ? mod_mask : 8'd0);
  end

  // Slot match and priority pick of the first empty slot.
  always_comb begin
    present    = 1'b0;
    any_free   = 1'b0;
    first_free = '0;
    for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) begin
      if ({8'd0, slots[i]} == kk) present = 1'b1;
      if (slots[i] == 8'd0 && !any_free) begin
        first_free[i] = 1'b1;
        any_free      = 1'b1;
      end
    end
  end

  // Next report contents for the current request.
  always_comb begin
    modifier_next = modifier_bits;
    media_next    = media_bits;
    status_next   = 1'b0;
    for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) slots_next[i] = slots[i];
    case (req_type)
      hkrb_pkg::REQ_PRESS: begin
        if (is_media) begin
          media_next = media_bits | media_mask;
        end else begin
          modifier_next = modifier_bits | set_mask;
          if (!present) begin
            if (any_free) begin
              for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
                if (first_free[i]) slots_next[i] = kk[7:0];
            end else begin
              status_next = 1'b1;
            end
          end
        end
      end
      hkrb_pkg::REQ_RELEASE: begin
        if (is_media) begin
          media_next = media_bits & ~media_mask;
        end else begin
          modifier_next = modifier_bits & ~set_mask;
          if (kk != 16'd0) begin
            for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
              if ({8'd0, slots[i]} == kk) slots_next[i] = 8'd0;
          end
        end
      end
      hkrb_pkg::REQ_RELEASE_ALL: begin
        modifier_next = 8'd0;
        media_next    = 8'd0;
        for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) slots_next[i] = 8'd0;
      end
      hkrb_pkg::REQ_RELEASE_SFT: begin
        modifier_next = modifier_bits & ~hkrb_pkg::BOTH_SHIFT_BITS;
        for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
          if (slots[i] == hkrb_pkg::LSHIFT_CODE || slots[i] == hkrb_pkg::RSHIFT_CODE)
            slots_next[i] = 8'd0;
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

  // Report state doubles as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_bits <= 8'd0;
      media_bits    <= 8'd0;
      for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) slots[i] <= 8'd0;
    end else if (cmd.load) begin
      modifier_bits <= modifier_next;
      media_bits    <= media_next;
      for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) slots[i] <= slots_next[i];
    end
  end

  // Status flag of the latest request.
  always_ff @(posedge clk) begin
    if (cmd.load) status <= status_next;
  end

endmodule

@@ src/hid_key_report_builder.sv @@
// HID key report builder: six-key report, modifier byte and media bitmap.
// The result is valid in the cycle after a request is accepted.
// Throughput: one request per cycle while results are taken; the result register
// alone sets this, since all slot compares finish in the accepting cycle.
// Reset clears the modifier byte, all key slots and the media bitmap.
// Depends on hkrb_pkg, hkrb_ctrl and hkrb_datapath.
module hid_key_report_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  modifier_bits,
  output logic [7:0]  slot0,
  output logic [7:0]  slot1,
  output logic [7:0]  slot2,
  output logic [7:0]  slot3,
  output logic [7:0]  slot4,
  output logic [7:0]  slot5,
  output logic [7:0]  media_bits,
  output logic        status
);

  hkrb_pkg::ctrl_cmd_t cmd;
  logic [7:0] slots [hkrb_pkg::NUM_SLOTS];

  // Handshake controller.
  hkrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Report state and update logic.
  hkrb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .key_code      (key_code),
    .modifier_bits (modifier_bits),
    .slots         (slots),
    .media_bits    (media_bits),
    .status        (status)
  );

  assign slot0 = slots[0];
  assign slot1 = slots[1];
  assign slot2 = slots[2];
  assign slot3 = slots[3];
  assign slot4 = slots[4];
  assign slot5 = slots[5];

endmodule

@@ verif/tb_hid_key_report_builder.sv @@
// Self-checking testbench for hid_key_report_builder: directed and random key requests,
// each report predicted in the bench and compared field by field with the block's output.
// Depends on hkrb_pkg and the hid_key_report_builder RTL.
module tb_hid_key_report_builder;

  localparam int RANDOM_REQUESTS = 1750;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TAIL_REQUESTS   = 120;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] code;
    bit          drain_first;
  } key_request_t;

  typedef struct packed {
    logic [7:0]                          mods;
    logic [hkrb_pkg::NUM_SLOTS-1:0][7:0] slots;
    logic [7:0]                          media;
    logic                                status;
  } key_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = hkrb_pkg::REQ_PRESS;
  logic [15:0] key_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  modifier_bits;
  logic [7:0]  slot0, slot1, slot2, slot3, slot4, slot5;
  logic [7:0]  media_bits;
  logic        status;

  key_request_t pending_requests[$];
  key_report_t  expected_reports[$];

  // Predicted report state.
  logic [7:0] held_mods;
  logic [7:0] held_slots [hkrb_pkg::NUM_SLOTS];
  logic [7:0] held_media;

  int cycle_count = 0;
  int error_count = 0;
  int sent_count  = 0;
  int report_count = 0;
  int full_count  = 0;
  int send_gap    = 0;
  int send_calm   = 0;
  int recv_gap    = 0;
  int recv_calm   = 0;

  hid_key_report_builder i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .key_code      (key_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .modifier_bits (modifier_bits),
    .slot0         (slot0),
    .slot1         (slot1),
    .slot2         (slot2),
    .slot3         (slot3),
    .slot4         (slot4),
    .slot5         (slot5),
    .media_bits    (media_bits),
    .status        (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Applies one request to the predicted state and returns the report it should produce.
  function automatic key_report_t apply_request(logic [1:0] req, logic [15:0] code);
    key_report_t rep;
    logic [15:0] kk;
    logic [7:0]  bit_mask;
    logic        set;
    logic        hit;
    int          free_at;
    rep.status = 1'b0;
    kk = code;
    case (req)
      hkrb_pkg::REQ_PRESS, hkrb_pkg::REQ_RELEASE: begin
        set = (req == hkrb_pkg::REQ_PRESS);
        if (code >= hkrb_pkg::MEDIA_FIRST && code <= hkrb_pkg::MEDIA_LAST) begin
          bit_mask = 8'h01 << (code - hkrb_pkg::MEDIA_FIRST);
          held_media = set ? (held_media | bit_mask) : (held_media & ~bit_mask);
        end else begin
          // The shift flag turns into left shift and leaves only the usage byte.
          if ((code & hkrb_pkg::SHIFT_FLAG_MASK) != 16'd0) begin
            held_mods = set ? (held_mods | hkrb_pkg::LSHIFT_BIT)
                            : (held_mods & ~hkrb_pkg::LSHIFT_BIT);
            kk = code & 16'h00FF;
          end
          // Modifier usages become modifier bits and leave no key behind.
          if (kk >= hkrb_pkg::MOD_FIRST && kk <= hkrb_pkg::MOD_LAST) begin
            bit_mask = 8'h01 << (kk - hkrb_pkg::MOD_FIRST);
            held_mods = set ? (held_mods | bit_mask) : (held_mods & ~bit_mask);
            kk = 16'd0;
          end
          if (set) begin
            hit = 1'b0;
            for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
              if ({8'h00, held_slots[i]} == kk) hit = 1'b1;
            if (!hit) begin
              free_at = -1;
              for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
                if (free_at < 0 && held_slots[i] == 8'h00) free_at = i;
              if (free_at >= 0) held_slots[free_at] = kk[7:0];
              else rep.status = 1'b1;
            end
          end else if (kk != 16'd0) begin
            for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
              if ({8'h00, held_slots[i]} == kk) held_slots[i] = 8'h00;
          end
        end
      end
      hkrb_pkg::REQ_RELEASE_ALL: begin
        for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) held_slots[i] = 8'h00;
        held_mods  = 8'h00;
        held_media = 8'h00;
      end
      default: begin
        held_mods = held_mods & ~hkrb_pkg::BOTH_SHIFT_BITS;
        for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
          if (held_slots[i] == hkrb_pkg::LSHIFT_CODE ||
              held_slots[i] == hkrb_pkg::RSHIFT_CODE)
            held_slots[i] = 8'h00;
      end
    endcase
    rep.mods  = held_mods;
    rep.media = held_media;
    for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) rep.slots[i] = held_slots[i];
    return rep;
  endfunction

  task automatic push_request(logic [1:0] req, logic [15:0] code, bit drain_first);
    key_request_t item;
    item.req = req;
    item.code = code;
    item.drain_first = drain_first;
    pending_requests.push_back(item);
  endtask

  // A small key pool keeps slots filling up, matching and overflowing.
  function automatic logic [15:0] random_key_code();
    int pick;
    logic [7:0] low;
    pick = $urandom_range(0, 99);
    low = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(4, 12)) : 8'($urandom_range(0, 255));
    if (pick < 45) return 16'($urandom_range(4, 12));
    else if (pick < 55) return hkrb_pkg::MOD_FIRST + 16'($urandom_range(0, 7));
    else if (pick < 65)
      return (16'($urandom) & 16'hEF00) | hkrb_pkg::SHIFT_FLAG_MASK | {8'h00, low};
    else if (pick < 73) return hkrb_pkg::MEDIA_FIRST + 16'($urandom_range(0, 7));
    else if (pick < 81) begin
      case ($urandom_range(0, 2))
        0:       low = hkrb_pkg::LSHIFT_CODE;
        1:       low = hkrb_pkg::RSHIFT_CODE;
        default: low = 8'($urandom_range(4, 12));
      endcase
      return {(8'($urandom_range(1, 255)) & 8'hEF), low};
    end
    else if (pick < 91) return 16'($urandom_range(0, 65535));
    else return 16'd0;
  endfunction

  function automatic logic [1:0] random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 52) return hkrb_pkg::REQ_PRESS;
    else if (pick < 88) return hkrb_pkg::REQ_RELEASE;
    else if (pick < 92) return hkrb_pkg::REQ_RELEASE_ALL;
    else return hkrb_pkg::REQ_RELEASE_SFT;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Request driver: presents the pending requests one at a time.
  always @(posedge clk) begin
    logic nxt_valid;
    key_request_t front;
    bit tail;
    if (rst) begin
      in_valid <= 1'b0;
      held_mods  = 8'h00;
      held_media = 8'h00;
      for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++) held_slots[i] = 8'h00;
    end else begin
      tail = (pending_requests.size() < TAIL_REQUESTS);
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        expected_reports.push_back(apply_request(req_type, key_code));
        sent_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() == 0) begin
          nxt_valid = 1'b0;
        end else if (pending_requests[0].drain_first && expected_reports.size() != 0) begin
          nxt_valid = 1'b0;
        end else if (!tail && send_calm == 0 && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(1, 17) - 1;
        end else begin
          front = pending_requests.pop_front();
          req_type <= front.req;
          key_code <= front.code;
          nxt_valid = 1'b1;
        end
      end
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(20, 120);
      in_valid <= nxt_valid;
    end
  end

  // Report monitor: checks each accepted report and throttles out_ready.
  always @(posedge clk) begin
    key_report_t want;
    key_report_t got;
    if (rst) begin
      out_ready <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        got.mods   = modifier_bits;
        got.slots  = {slot5, slot4, slot3, slot2, slot1, slot0};
        got.media  = media_bits;
        got.status = status;
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: report expected none, got %0h", $time, got);
        end else begin
          want = expected_reports.pop_front();
          report_count++;
          if (want.status) full_count++;
          check_field("modifier_bits", want.mods, got.mods);
          for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
            check_field($sformatf("slot%0d", i), want.slots[i], got.slots[i]);
          check_field("media_bits", want.media, got.media);
          check_field("status", {7'd0, want.status}, {7'd0, got.status});
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (pending_requests.size() < TAIL_REQUESTS || recv_calm > 0) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 59) == 0) recv_calm = $urandom_range(20, 120);
    end
  end

  initial begin
    // Directed part: fill the slots through every kind of code, overflow, then release.
    push_request(hkrb_pkg::REQ_PRESS, 16'd0, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'd4, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'd4, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::SHIFT_FLAG_MASK | 16'd5, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::MOD_FIRST, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::MOD_LAST, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::SHIFT_FLAG_MASK | 16'd229, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::MEDIA_FIRST, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::MEDIA_LAST, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'h01E1, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'h02E5, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'hFFFF, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'hEF00, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'd6, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'd7, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, 16'd226, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE, 16'd4, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE, 16'h0104, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE_SFT, 16'h1234, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE, hkrb_pkg::SHIFT_FLAG_MASK | 16'd5, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE, hkrb_pkg::MEDIA_LAST, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE, hkrb_pkg::MOD_LAST, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE, 16'd0, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::MEDIA_LAST + 16'd1, 1'b0);
    push_request(hkrb_pkg::REQ_PRESS, hkrb_pkg::MEDIA_FIRST - 16'd1, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE_ALL, 16'hFFFF, 1'b0);
    push_request(hkrb_pkg::REQ_RELEASE_SFT, 16'd0, 1'b0);

    // Random part; now and then the sender waits for every report to come back.
    for (int n = 0; n < RANDOM_REQUESTS; n++)
      push_request(random_req(), random_key_code(), (n % 400) == 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_requests.size() == 0 && !in_valid && expected_reports.size() == 0)
           && cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, expected_reports.size());
      $display("hid_key_report_builder: mismatch");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("Sent %0d requests, checked %0d reports, %0d of them with no free slot.",
               sent_count, report_count, full_count);
      $display("Field mismatches and stray reports: %0d.", error_count);
      if (error_count == 0) begin
        $display("hid_key_report_builder: match");
      end else begin
        $display("hid_key_report_builder: mismatch");
      end
    end
    $finish;
  end

endmodule
